// ===== src/assert_macros.svh =====
// assertion helper macros used by the lfu cache table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication check
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication check
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lfu_pkg.sv =====
// shared types and constants for the lfu cache table
package lfu_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int REC_W   = IDX_W;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int WORD_W  = 32;

   // recency update kinds broadcast to the cells
   localparam logic [1:0] INC_NONE  = 2'd0;
   localparam logic [1:0] INC_ALL   = 2'd1;
   localparam logic [1:0] INC_BELOW = 2'd2;
   localparam logic [1:0] INC_UPTO  = 2'd3;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic                     mode;
      logic signed [WORD_W-1:0] key;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [WORD_W-1:0] data;
      logic                     evicted;
      logic signed [WORD_W-1:0] evicted_key;
   } rsp_type;

   // update command from the sequencer to every cell
   typedef struct packed {
      logic              apply;
      logic [IDX_W-1:0]  slot;
      logic              insert;
      logic              set_value;
      logic [1:0]        inc_mode;
      logic [REC_W-1:0]  thr;
      logic [WORD_W-1:0] key;
      logic [WORD_W-1:0] value;
   } cmd_type;

   // running victim candidate handed along the chain
   typedef struct packed {
      logic              present;
      logic [WORD_W-1:0] count;
      logic [REC_W-1:0]  recency;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] key;
   } best_type;

   // per-cell status seen by the sequencer
   typedef struct packed {
      logic              valid;
      logic              match;
      logic [WORD_W-1:0] value;
      logic [REC_W-1:0]  recency;
   } cell_stat_type;

endpackage

// ===== src/lfu_cache_table.sv =====
// lfu cache table top: request sequencer over a chain of entry cells
// gets, hits and puts into a free entry give their result from the lookup state; a put that
// evicts first scans the chain (victim candidate ripples one cell per cycle) before its result
// a new request is taken only in idle, once the last result is registered; a stalled output holds it
// reset: all entries invalid, capacity 16, no result pending
module lfu_cache_table import lfu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CAP_W-1:0] csr_data
);
`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cmd_type          cmd;
   cell_stat_type    stat [ENTRIES];
   best_type         chain [ENTRIES+1];
   logic [ENTRIES-1:0] match_vec;

   logic              any_hit;
   logic [WORD_W-1:0] hit_value;
   logic [REC_W-1:0]  hit_rec;
   logic [IDX_W-1:0]  hit_idx;
   logic [IDX_W-1:0]  free_idx;
   logic [CNT_W-1:0]  used;
   logic [CMP_W-1:0]  cap_lim;
   logic              full, disabled, out_free, fire;

   // cell row
   assign chain[0] = '0;
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lfu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_W'(g)),
         .look_key  (req_ff.key),
         .cmd       (cmd),
         .best_prev (chain[g]),
         .best_out  (chain[g+1]),
         .stat      (stat[g])
      );
      assign match_vec[g] = stat[g].match;
   end

   // gather match, occupancy and first free entry
   always_comb begin
      hit_value = '0;
      hit_rec   = '0;
      hit_idx   = '0;
      free_idx  = '0;
      used      = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (stat[i].match) begin
            hit_value = hit_value | stat[i].value;
            hit_rec   = hit_rec | stat[i].recency;
            hit_idx   = hit_idx | IDX_W'(i);
         end
         used = used + CNT_W'(stat[i].valid);
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!stat[i].valid) free_idx = IDX_W'(i);
      end
      any_hit = |match_vec;
      cap_lim = (CMP_W'(cap_ff) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(cap_ff);
      full     = CMP_W'(used) >= cap_lim;
      disabled = cap_lim == '0;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer, update command and result
   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      req_in       = req_ff;
      scan_in      = scan_ff;
      rsp_in       = rsp_ff;
      fire         = 1'b0;
      cmd          = '0;
      cmd.key      = req_ff.key;
      cmd.value    = req_ff.value;
      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) cap_in = csr_data;
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!disabled && !any_hit && req_ff.mode == MODE_PUT && full) begin
               scan_in  = '0;
               state_in = ST_SCAN;
            end else if (out_free) begin
               fire     = 1'b1;
               state_in = ST_IDLE;
               rsp_in   = '0;
               if (!disabled) begin
                  if (any_hit) begin
                     rsp_in.hit    = 1'b1;
                     if (req_ff.mode == MODE_GET) rsp_in.data = hit_value;
                     cmd.apply     = 1'b1;
                     cmd.slot      = hit_idx;
                     cmd.set_value = req_ff.mode == MODE_PUT;
                     cmd.inc_mode  = INC_BELOW;
                     cmd.thr       = hit_rec;
                  end else if (req_ff.mode == MODE_PUT) begin
                     cmd.apply     = 1'b1;
                     cmd.slot      = free_idx;
                     cmd.insert    = 1'b1;
                     cmd.inc_mode  = INC_ALL;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff != IDX_W'(ENTRIES - 1)) begin
               scan_in = scan_ff + IDX_W'(1);
            end else if (out_free) begin
               fire               = 1'b1;
               state_in           = ST_IDLE;
               rsp_in             = '0;
               rsp_in.evicted     = 1'b1;
               rsp_in.evicted_key = chain[ENTRIES].key;
               cmd.apply          = 1'b1;
               cmd.slot           = chain[ENTRIES].idx;
               cmd.insert         = 1'b1;
               cmd.inc_mode       = INC_UPTO;
               cmd.thr            = chain[ENTRIES].recency;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      scan_ff <= scan_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `CHK_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "no stall after accept")
   `CHK_IMPLY(a_unique_key, clock, reset, 1'b1, $onehot0(match_vec), "key matches several entries")
   `CHK_IMPLY(a_hit_no_evict, clock, reset, rsp_valid, !(rsp_data.hit && rsp_data.evicted), "hit with eviction")

endmodule

// ===== src/lfu_cell.sv =====
// one table entry with key match, update and a victim chain stage
module lfu_cell import lfu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [IDX_W-1:0]  cell_idx,
   input  logic [WORD_W-1:0] look_key,
   input  cmd_type           cmd,
   input  best_type          best_prev,
   output best_type          best_out,
   output cell_stat_type     stat
);

   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] key_ff, key_in;
   logic [WORD_W-1:0] value_ff, value_in;
   logic [WORD_W-1:0] count_ff, count_in;
   logic [REC_W-1:0]  rec_ff, rec_in;
   best_type          best_ff, best_in;
   logic              take_own;

   // victim compare against the neighbor's candidate
   always_comb begin
      take_own = valid_ff && (!best_prev.present || (count_ff < best_prev.count) ||
                 ((count_ff == best_prev.count) && (rec_ff > best_prev.recency)));
      if (take_own) begin
         best_in.present = 1'b1;
         best_in.count   = count_ff;
         best_in.recency = rec_ff;
         best_in.idx     = cell_idx;
         best_in.key     = key_ff;
      end else begin
         best_in = best_prev;
      end
   end

   // entry update
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rec_in   = rec_ff;
      if (cmd.apply) begin
         if (cmd.slot == cell_idx) begin
            rec_in = '0;
            if (cmd.insert) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               value_in = cmd.value;
               count_in = WORD_W'(1);
            end else begin
               count_in = (&count_ff) ? count_ff : count_ff + WORD_W'(1);
               if (cmd.set_value) begin
                  value_in = cmd.value;
               end
            end
         end else if (valid_ff) begin
            case (cmd.inc_mode)
               INC_ALL:   rec_in = rec_ff + REC_W'(1);
               INC_BELOW: if (rec_ff < cmd.thr) rec_in = rec_ff + REC_W'(1);
               INC_UPTO:  if (rec_ff <= cmd.thr) rec_in = rec_ff + REC_W'(1);
               default:   rec_in = rec_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         best_ff.present <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         best_ff.present <= best_in.present;
      end
      key_ff          <= key_in;
      value_ff        <= value_in;
      count_ff        <= count_in;
      rec_ff          <= rec_in;
      best_ff.count   <= best_in.count;
      best_ff.recency <= best_in.recency;
      best_ff.idx     <= best_in.idx;
      best_ff.key     <= best_in.key;
   end

   assign best_out      = best_ff;
   assign stat.valid    = valid_ff;
   assign stat.match    = valid_ff && (key_ff == look_key);
   assign stat.value    = value_ff;
   assign stat.recency  = rec_ff;

endmodule
